// ===== hdl/rszs_pkg.sv =====
// Shared widths, constants and types for the rank-sum z-score block.
package rszs_pkg;

  localparam int IN_W       = 16;          // width of a count field on the bus
  localparam int COUNT_BITS = 16;          // low bits of a count that are used
  localparam int MAX_TOTAL  = 1048576;     // cap on the combined count
  localparam int TOT_W      = 21;          // group totals
  localparam int RS_W       = 43;          // doubled rank sums
  localparam int R2_W       = 22;          // doubled midrank of a bin
  localparam int ALU_W      = 88;          // shared adder, holds 3*a*a
  localparam int P_W        = 64;          // variance term, also quotient width
  localparam int FRAC_W     = 32;          // z^2 carries 32 fraction bits
  localparam int Q_W        = 32;          // root width
  localparam int Z_W        = 32;          // result width

  localparam int DIV_STEPS  = ALU_W + FRAC_W;
  localparam int SQRT_STEPS = P_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [P_W-1:0] P_SMALL = P_W'(12);
  localparam logic [Z_W-1:0] Z_MAX   = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0] Z_MIN   = {1'b1, {(Z_W-1){1'b0}}};

  typedef logic [ALU_W-1:0]      alu_word_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TOT_W-1:0]      total_t;
  typedef logic [RS_W-1:0]       rank_t;
  typedef logic [R2_W-1:0]       rank2_t;
  typedef logic [CNT_W-1:0]      step_t;

  typedef struct packed {
    alu_word_t a;
    alu_word_t b;
    logic      sub;
  } alu_op_t;

  typedef struct packed {
    alu_word_t sum;
    logic      borrow;
  } alu_res_t;

endpackage

// ===== hdl/rszs_alu.sv =====
// Shared add/subtract unit with borrow out, used by the sequencer's arithmetic states.
module rszs_alu
  import rszs_pkg::*;
(
  input  alu_op_t  op,
  output alu_res_t res
);

  alu_word_t  b_in;
  logic [ALU_W:0] full;

  assign b_in = op.sub ? ~op.b : op.b;
  assign full = {1'b0, op.a} + {1'b0, b_in} + (ALU_W+1)'(op.sub);

  assign res.sum    = full[ALU_W-1:0];
  assign res.borrow = op.sub & ~full[ALU_W];

endmodule

// ===== hdl/rszs_clamp.sv =====
// Count limiting and doubled midrank for one incoming bin.
module rszs_clamp
  import rszs_pkg::*;
(
  input  total_t          total_ref,
  input  total_t          total_alt,
  input  logic [IN_W-1:0] ref_in,
  input  logic [IN_W-1:0] alt_in,
  output count_t          c1,
  output count_t          c2,
  output rank2_t          r2
);

  logic [TOT_W:0] n;
  total_t         room;
  total_t         room2;
  count_t         cin1;
  count_t         cin2;

  always_comb begin
    n    = {1'b0, total_ref} + {1'b0, total_alt};
    room = (n < (TOT_W+1)'(MAX_TOTAL)) ? TOT_W'(MAX_TOTAL - int'(n)) : '0;
    cin1 = ref_in[COUNT_BITS-1:0];
    cin2 = alt_in[COUNT_BITS-1:0];
    // reference count takes the room first, alternate gets what is left
    c1    = (TOT_W'(cin1) > room) ? COUNT_BITS'(room) : cin1;
    room2 = room - TOT_W'(c1);
    c2    = (TOT_W'(cin2) > room2) ? COUNT_BITS'(room2) : cin2;
    r2    = R2_W'({n, 1'b0}) + R2_W'(c1) + R2_W'(c2) + R2_W'(1);
  end

endmodule

// ===== hdl/rank_sum_z_score.sv =====
// Top level: bin accumulation and z-score sequencer around one shared adder.
//
//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+----------------------
//  in_     | in  | tdata[15:0] ref_count, [31:16] alt_count| tvalid/tready, tlast
//          |     | tlast last_bin                         |
//  out_    | out | tdata[31:0] z_score (signed Q15.16)    | tvalid/tready
//
// A bin's accept is followed by two 16-step shift-add multiplies through the
// shared adder. A last bin then adds three 21-step multiplies, a 43-step square,
// a 120-step restoring divide, a 32-step square root and four single steps
// (five when w lies below the mean); small variance or saturation cut it short.
// Reset clears the totals, the rank sums and the output word.
// A held output word does not block new bins; a finished score waits in its
// final step until the output register is free.
module rank_sum_z_score
  import rszs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] ref_count, [31:16] alt_count
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] z_score
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_BIN_REF = 13'b0000000000010,
    ST_BIN_ALT = 13'b0000000000100,
    ST_SEL     = 13'b0000000001000,
    ST_M2      = 13'b0000000010000,
    ST_PM1     = 13'b0000000100000,
    ST_PM2     = 13'b0000001000000,
    ST_ABS     = 13'b0000010000000,
    ST_SQ      = 13'b0000100000000,
    ST_TRIPLE  = 13'b0001000000000,
    ST_DIV     = 13'b0010000000000,
    ST_SQRT    = 13'b0100000000000,
    ST_FIN     = 13'b1000000000000
  } state_t;

  state_t          state_r, state_nxt;
  step_t           cnt_r, cnt_nxt;
  alu_word_t       acc_r, acc_nxt;
  alu_word_t       mcand_r, mcand_nxt;
  rank_t           mplier_r, mplier_nxt;
  logic [P_W-1:0]  quo_r, quo_nxt;
  logic            sat_r, sat_nxt;
  logic            neg_r, neg_nxt;
  logic            last_r, last_nxt;
  count_t          c2_r, c2_nxt;
  rank2_t          r2_r, r2_nxt;
  total_t          tot_ref_r, tot_ref_nxt;
  total_t          tot_alt_r, tot_alt_nxt;
  rank_t           rs_ref_r, rs_ref_nxt;
  rank_t           rs_alt_r, rs_alt_nxt;
  total_t          n1_r, n1_nxt;
  total_t          n2_r, n2_nxt;
  total_t          np1_r, np1_nxt;
  rank_t           w2_r, w2_nxt;
  rank_t           m2_r, m2_nxt;
  logic [P_W-1:0]  p_r, p_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [Z_W-1:0]  out_data_r, out_data_nxt;

  alu_op_t         alu_op;
  alu_res_t        alu_res;
  count_t          cl_c1;
  count_t          cl_c2;
  rank2_t          cl_r2;
  alu_word_t       acc_step;
  alu_word_t       rem_div;
  alu_word_t       rem_sqrt;
  logic            step_done;
  logic            in_acc;
  logic            swap;
  total_t          n1_sel;
  total_t          n2_sel;
  total_t          np1_sel;
  logic            qbit;
  logic [Q_W-1:0]  root;
  logic [Z_W-1:0]  z_val;

  rszs_clamp u_clamp (
    .total_ref (tot_ref_r),
    .total_alt (tot_alt_r),
    .ref_in    (in_tdata[15:0]),
    .alt_in    (in_tdata[31:16]),
    .c1        (cl_c1),
    .c2        (cl_c2),
    .r2        (cl_r2)
  );

  rszs_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign step_done = (cnt_r == '0);
  assign acc_step  = mplier_r[0] ? alu_res.sum : acc_r;
  assign rem_div   = {acc_r[ALU_W-2:0], mcand_r[ALU_W-1]};
  assign rem_sqrt  = {acc_r[ALU_W-3:0], quo_r[P_W-1 -: 2]};
  assign qbit      = ~alu_res.borrow;
  assign root      = mplier_r[Q_W-1:0];

  assign swap    = (rs_ref_r > rs_alt_r);
  assign n1_sel  = swap ? tot_alt_r : tot_ref_r;
  assign n2_sel  = swap ? tot_ref_r : tot_alt_r;
  assign np1_sel = n1_sel + n2_sel + TOT_W'(1);

  // clamp the root onto the signed range; the adder supplies -root
  always_comb begin
    if (!neg_r) begin
      z_val = root[Q_W-1] ? Z_MAX : Z_W'(root);
    end else begin
      z_val = (Z_W'(root) > Z_MIN) ? Z_MIN : alu_res.sum[Z_W-1:0];
    end
  end

  // operand select for the shared adder
  always_comb begin
    alu_op = '0;
    unique case (state_r) inside
      ST_BIN_REF, ST_BIN_ALT, ST_M2, ST_PM1, ST_PM2, ST_SQ: begin
        alu_op.a = acc_r;
        alu_op.b = mcand_r;
      end
      ST_ABS: begin
        alu_op.a   = alu_word_t'(neg_r ? m2_r : w2_r);
        alu_op.b   = alu_word_t'(neg_r ? w2_r : m2_r);
        alu_op.sub = 1'b1;
      end
      ST_TRIPLE: begin
        alu_op.a = acc_r;
        alu_op.b = {acc_r[ALU_W-2:0], 1'b0};
      end
      ST_DIV: begin
        alu_op.a   = rem_div;
        alu_op.b   = alu_word_t'(p_r);
        alu_op.sub = 1'b1;
      end
      ST_SQRT: begin
        alu_op.a   = rem_sqrt;
        alu_op.b   = alu_word_t'({root, 2'b01});
        alu_op.sub = 1'b1;
      end
      ST_FIN: begin
        alu_op.b   = alu_word_t'(root);
        alu_op.sub = 1'b1;
      end
      default: alu_op = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    c2_nxt        = c2_r;
    r2_nxt        = r2_r;
    tot_ref_nxt   = tot_ref_r;
    tot_alt_nxt   = tot_alt_r;
    rs_ref_nxt    = rs_ref_r;
    rs_alt_nxt    = rs_alt_r;
    n1_nxt        = n1_r;
    n2_nxt        = n2_r;
    np1_nxt       = np1_r;
    w2_nxt        = w2_r;
    m2_nxt        = m2_r;
    p_nxt         = p_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    // shift-add multiply step, overridden below where unused
    if (state_r == ST_BIN_REF || state_r == ST_BIN_ALT || state_r == ST_M2 ||
        state_r == ST_PM1 || state_r == ST_PM2 || state_r == ST_SQ) begin
      acc_nxt    = acc_step;
      mcand_nxt  = {mcand_r[ALU_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[RS_W-1:1]};
      cnt_nxt    = cnt_r - step_t'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          tot_ref_nxt = tot_ref_r + TOT_W'(cl_c1);
          tot_alt_nxt = tot_alt_r + TOT_W'(cl_c2);
          c2_nxt      = cl_c2;
          r2_nxt      = cl_r2;
          last_nxt    = in_tlast;
          acc_nxt     = alu_word_t'(rs_ref_r);
          mcand_nxt   = alu_word_t'(cl_r2);
          mplier_nxt  = rank_t'(cl_c1);
          cnt_nxt     = step_t'(COUNT_BITS - 1);
          state_nxt   = ST_BIN_REF;
        end
      end
      ST_BIN_REF: begin
        if (step_done) begin
          rs_ref_nxt = acc_step[RS_W-1:0];
          acc_nxt    = alu_word_t'(rs_alt_r);
          mcand_nxt  = alu_word_t'(r2_r);
          mplier_nxt = rank_t'(c2_r);
          cnt_nxt    = step_t'(COUNT_BITS - 1);
          state_nxt  = ST_BIN_ALT;
        end
      end
      ST_BIN_ALT: begin
        if (step_done) begin
          rs_alt_nxt = acc_step[RS_W-1:0];
          state_nxt  = last_r ? ST_SEL : ST_IDLE;
        end
      end
      ST_SEL: begin
        // latch the smaller-sum group, then drop the running state
        n1_nxt      = n1_sel;
        n2_nxt      = n2_sel;
        np1_nxt     = np1_sel;
        w2_nxt      = swap ? rs_alt_r : rs_ref_r;
        tot_ref_nxt = '0;
        tot_alt_nxt = '0;
        rs_ref_nxt  = '0;
        rs_alt_nxt  = '0;
        neg_nxt     = 1'b0;
        acc_nxt     = '0;
        mcand_nxt   = alu_word_t'(n1_sel);
        mplier_nxt  = rank_t'(np1_sel);
        cnt_nxt     = step_t'(TOT_W - 1);
        state_nxt   = ST_M2;
      end
      ST_M2: begin
        if (step_done) begin
          m2_nxt     = acc_step[RS_W-1:0];
          acc_nxt    = '0;
          mcand_nxt  = alu_word_t'(n1_r);
          mplier_nxt = rank_t'(n2_r);
          cnt_nxt    = step_t'(TOT_W - 1);
          state_nxt  = ST_PM1;
        end
      end
      ST_PM1: begin
        if (step_done) begin
          acc_nxt    = '0;
          mcand_nxt  = acc_step;
          mplier_nxt = rank_t'(np1_r);
          cnt_nxt    = step_t'(TOT_W - 1);
          state_nxt  = ST_PM2;
        end
      end
      ST_PM2: begin
        if (step_done) begin
          p_nxt     = acc_step[P_W-1:0];
          state_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        if (p_r < P_SMALL) begin
          // deviation below one: score is zero
          mplier_nxt = '0;
          neg_nxt    = 1'b0;
          state_nxt  = ST_FIN;
        end else if (alu_res.borrow && !neg_r) begin
          neg_nxt = 1'b1;
        end else begin
          acc_nxt    = '0;
          mcand_nxt  = alu_word_t'(alu_res.sum[RS_W-1:0]);
          mplier_nxt = alu_res.sum[RS_W-1:0];
          cnt_nxt    = step_t'(RS_W - 1);
          state_nxt  = ST_SQ;
        end
      end
      ST_SQ: begin
        if (step_done) begin
          state_nxt = ST_TRIPLE;
        end
      end
      ST_TRIPLE: begin
        // dividend 3*a*a goes to the shift register, remainder starts at zero
        mcand_nxt = alu_res.sum;
        acc_nxt   = '0;
        quo_nxt   = '0;
        sat_nxt   = 1'b0;
        cnt_nxt   = step_t'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        acc_nxt   = qbit ? alu_res.sum : rem_div;
        quo_nxt   = {quo_r[P_W-2:0], qbit};
        sat_nxt   = sat_r | quo_r[P_W-1];
        mcand_nxt = {mcand_r[ALU_W-2:0], 1'b0};
        cnt_nxt   = cnt_r - step_t'(1);
        if (step_done) begin
          if (sat_r | quo_r[P_W-1]) begin
            mplier_nxt = rank_t'({Q_W{1'b1}});
            state_nxt  = ST_FIN;
          end else begin
            acc_nxt    = '0;
            mplier_nxt = '0;
            cnt_nxt    = step_t'(SQRT_STEPS - 1);
            state_nxt  = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        acc_nxt    = qbit ? alu_res.sum : rem_sqrt;
        mplier_nxt = rank_t'({root, qbit});
        quo_nxt    = {quo_r[P_W-3:0], 2'b00};
        cnt_nxt    = cnt_r - step_t'(1);
        if (step_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = z_val;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      tot_ref_r   <= '0;
      tot_alt_r   <= '0;
      rs_ref_r    <= '0;
      rs_alt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      tot_ref_r   <= tot_ref_nxt;
      tot_alt_r   <= tot_alt_nxt;
      rs_ref_r    <= rs_ref_nxt;
      rs_alt_r    <= rs_alt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    quo_r    <= quo_nxt;
    sat_r    <= sat_nxt;
    neg_r    <= neg_nxt;
    last_r   <= last_nxt;
    c2_r     <= c2_nxt;
    r2_r     <= r2_nxt;
    n1_r     <= n1_nxt;
    n2_r     <= n2_nxt;
    np1_r    <= np1_nxt;
    w2_r     <= w2_nxt;
    m2_r     <= m2_nxt;
    p_r      <= p_nxt;
  end

endmodule
